[design/counting_sort_engine_unit_assert.svh]
// Assertion macros used by the checker module of the counting sort engine.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef COUNTING_SORT_ENGINE_UNIT_ASSERT_SVH
`define COUNTING_SORT_ENGINE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

[design/cse_pkg.sv]
`timescale 1ns / 1ps

package cse_pkg;

  localparam int VALUE_BITS = 10;
  localparam int DEPTH = 1 << VALUE_BITS;
  localparam int MAX_ITEMS_DEFAULT = 64;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic                         last;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] sorted_value;
    logic                         end_of_run;
    logic                         overflow;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_LOAD,
    ST_FLUSH,
    ST_WALK_RD,
    ST_WALK_CNT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic walk_start;
    logic walk_rd;
    logic walk_load;
    logic emit;
    logic advance;
    logic run_clear;
  } cse_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic entry_zero;
    logic entry_last;
    logic run_last;
  } cse_status_t;

endpackage

[design/cse_controller.sv]
`timescale 1ns / 1ps

module cse_controller
  import cse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        last,
  input  cse_status_t status,
  output cse_cmd_t    cmd,
  output logic        busy,
  output logic        strobe
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (start && last) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        state_next = ST_WALK_RD;
      end
      ST_WALK_RD: begin
        state_next = ST_WALK_CNT;
      end
      ST_WALK_CNT: begin
        if (status.entry_zero) state_next = ST_WALK_RD;
        else state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.run_last) state_next = ST_LOAD;
        else if (status.entry_last) state_next = ST_WALK_RD;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd    = '0;
    busy   = 1'b1;
    strobe = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      ST_LOAD: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_FLUSH: begin
        cmd.walk_start = 1'b1;
      end
      ST_WALK_RD: begin
        cmd.walk_rd = 1'b1;
      end
      ST_WALK_CNT: begin
        cmd.walk_load = 1'b1;
        cmd.advance   = status.entry_zero;
      end
      ST_EMIT: begin
        strobe        = 1'b1;
        cmd.emit      = 1'b1;
        cmd.run_clear = status.run_last;
        cmd.advance   = !status.run_last && status.entry_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[design/cse_datapath.sv]
`timescale 1ns / 1ps

module cse_datapath
  import cse_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  item_t       item,
  input  cse_cmd_t    cmd,
  output cse_status_t status,
  output result_t     result
);

  localparam int CntW = $clog2(MAX_ITEMS + 1);
  localparam int Msb = VALUE_BITS - 1;

  logic [CntW-1:0] hist_mem [DEPTH];
  logic [CntW-1:0] rdata;

  logic [VALUE_BITS-1:0] idx;
  logic                  store;
  logic                  mem_we;
  logic [VALUE_BITS-1:0] mem_waddr;
  logic [CntW-1:0]       mem_wdata;
  logic                  mem_re;
  logic [VALUE_BITS-1:0] mem_raddr;

  // Pending increment of the previous item, with a bypass for back-to-back hits.
  logic                  st_valid;
  logic [VALUE_BITS-1:0] st_addr;
  logic                  st_hit;
  logic [CntW-1:0]       st_fwd;
  logic [CntW-1:0]       st_new;

  logic [CntW-1:0]       item_count;
  logic [VALUE_BITS-1:0] lowest_seen;
  logic [VALUE_BITS-1:0] highest_seen;
  logic                  dropped_flag;
  logic [VALUE_BITS-1:0] ptr;
  logic [CntW-1:0]       cnt;
  logic [CntW-1:0]       remaining;

  // Flipping the sign bit maps the signed range onto ascending indexes.
  assign idx    = {~item.value[Msb], item.value[Msb-1:0]};
  assign store  = cmd.load && (item_count != CntW'(MAX_ITEMS));
  assign st_new = (st_hit ? st_fwd : rdata) + CntW'(1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = st_addr;
    mem_wdata = st_new;
    if (cmd.clr_step || cmd.walk_rd) begin
      mem_we    = 1'b1;
      mem_waddr = ptr;
      mem_wdata = '0;
    end else if (st_valid) begin
      mem_we = 1'b1;
    end
  end

  assign mem_re    = store || cmd.walk_rd;
  assign mem_raddr = cmd.walk_rd ? ptr : idx;

  always_ff @(posedge clk) begin
    if (mem_we) hist_mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rdata <= hist_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (store) begin
      st_addr <= idx;
      st_hit  <= st_valid && (st_addr == idx);
      st_fwd  <= st_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid     <= 1'b0;
      item_count   <= '0;
      lowest_seen  <= '1;
      highest_seen <= '0;
      dropped_flag <= 1'b0;
      ptr          <= '0;
    end else begin
      st_valid <= store;
      if (store) begin
        item_count <= item_count + CntW'(1);
        if (idx < lowest_seen) lowest_seen <= idx;
        if (idx > highest_seen) highest_seen <= idx;
      end else if (cmd.load) begin
        dropped_flag <= 1'b1;
      end
      if (cmd.run_clear) begin
        item_count   <= '0;
        lowest_seen  <= '1;
        highest_seen <= '0;
        dropped_flag <= 1'b0;
      end
      if (cmd.clr_step || cmd.advance) begin
        ptr <= ptr + VALUE_BITS'(1);
      end else if (cmd.walk_start) begin
        ptr <= lowest_seen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      remaining <= item_count;
    end else if (cmd.emit) begin
      remaining <= remaining - CntW'(1);
    end
    if (cmd.walk_load) begin
      cnt <= rdata;
    end else if (cmd.emit) begin
      cnt <= cnt - CntW'(1);
    end
  end

  assign status.clear_last = &ptr;
  assign status.entry_zero = (rdata == '0);
  assign status.entry_last = (cnt == CntW'(1));
  assign status.run_last   = (remaining == CntW'(1));

  assign result.sorted_value = {~ptr[Msb], ptr[Msb-1:0]};
  assign result.end_of_run   = status.run_last;
  assign result.overflow     = dropped_flag;

endmodule

[design/counting_sort_engine_unit.sv]
`timescale 1ns / 1ps

// Counting sort engine for signed values.
// Input: an item (value, last) is taken at a rising edge where start is high
// and busy is low. While loading, busy stays low and one item is taken every
// cycle; each value increments its histogram entry through a registered
// read-modify-write with a bypass for repeated values.
// The item marked last raises busy; after a flush step the walk visits each
// histogram entry from the lowest to the highest value seen: it reads the
// entry, loads its count and emits one result per counted item; busy falls in
// the cycle after the result that carries end_of_run. Items beyond MAX_ITEMS
// in a run are dropped and every result of that run carries overflow.
// Output: each result is shown for one cycle with strobe high; the receiver
// cannot stall it. The walk clears the entries it visits.
// Reset: after rst a pass over all 1024 entries clears the histogram memory
// (one entry per cycle) with busy high; no item is taken during that pass.

module counting_sort_engine_unit
  import cse_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output result_t result,
  output logic    strobe
);

  cse_cmd_t    cmd;
  cse_status_t status;

  cse_controller u_controller (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .last   (item.last),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe)
  );

  cse_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

endmodule

[design/cse_checker.sv]
`timescale 1ns / 1ps

`include "counting_sort_engine_unit_assert.svh"

module cse_checker
  import cse_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input item_t   item,
  input result_t result,
  input logic    strobe
);

  // Results only come out during a walk.
  `CSE_ASSERT_SAME(a_strobe_busy, strobe, busy)

  // A transaction marked last starts the walk.
  `CSE_ASSERT_NEXT(a_last_busy, !rst && start && !busy && item.last, busy)

  // A transaction not marked last keeps the engine loading.
  `CSE_ASSERT_NEXT(a_load_ready, !rst && start && !busy && !item.last, !busy)

  // The end of a run returns to loading at once.
  `CSE_ASSERT_NEXT(a_end_idle, strobe && result.end_of_run, !strobe && !busy)

endmodule

bind counting_sort_engine_unit cse_checker u_cse_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .result (result),
  .strobe (strobe)
);

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import cse_pkg::*;

  localparam int CAPACITY = MAX_ITEMS_DEFAULT;
  localparam int HALF = DEPTH / 2;
  localparam int PHASE_ITEMS = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  item_t item = '0;
  logic busy;
  result_t result;
  logic strobe;

  typedef struct {
    item_t       payload;
    int unsigned gap_pct;
    bit          drain_first;
  } stim_t;

  stim_t item_backlog[$];
  result_t pending_sorted[$];

  // Software histogram, indexed by value with the sign bit flipped.
  int unsigned tally[DEPTH];
  int unsigned stored_count;
  int unsigned lowest_idx;
  int unsigned highest_idx;
  bit dropped;

  int unsigned items_taken;
  int unsigned runs_done;
  int unsigned overflow_runs;
  int unsigned results_checked;
  int unsigned failures;
  longint unsigned cycle_budget;
  longint unsigned cycle_limit = 64'hFFFF_FFFF;
  longint unsigned cycles;

  counting_sort_engine_unit #(
    .MAX_ITEMS(CAPACITY)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .result(result),
    .strobe(strobe)
  );

  always #1 clk = ~clk;

  function automatic void clear_histogram();
    for (int i = 0; i < DEPTH; i++) tally[i] = 0;
    stored_count = 0;
    lowest_idx = DEPTH - 1;
    highest_idx = 0;
    dropped = 1'b0;
  endfunction

  // Counts one accepted value; a last-marked item expands the histogram into
  // the ascending list of expected results.
  function automatic void sort_item(item_t it);
    int unsigned idx;
    int unsigned remaining;
    int unsigned c;
    int unsigned i;
    result_t r;
    idx = int'({~it.value[VALUE_BITS-1], it.value[VALUE_BITS-2:0]});
    items_taken++;
    if (stored_count < CAPACITY) begin
      tally[idx]++;
      stored_count++;
      if (idx < lowest_idx) lowest_idx = idx;
      if (idx > highest_idx) highest_idx = idx;
    end else begin
      dropped = 1'b1;
    end
    if (!it.last) return;
    remaining = stored_count;
    for (i = lowest_idx; i <= highest_idx; i++) begin
      c = tally[i];
      while (c > 0 && remaining > 0) begin
        r.sorted_value = VALUE_BITS'(i ^ HALF);
        remaining--;
        r.end_of_run = (remaining == 0);
        r.overflow = dropped;
        pending_sorted.push_back(r);
        c--;
      end
    end
    runs_done++;
    if (dropped) overflow_runs++;
    clear_histogram();
  endfunction

  function automatic void queue_item(logic [VALUE_BITS-1:0] v, bit lst, int unsigned gap,
                                     bit drain);
    stim_t s;
    s.payload.value = v;
    s.payload.last = lst;
    s.gap_pct = gap;
    s.drain_first = drain;
    item_backlog.push_back(s);
    cycle_budget += 64;
    if (lst) cycle_budget += 2 * DEPTH + CAPACITY + 32;
  endfunction

  // Most runs are short; a tenth of them sit around the capacity limit.
  // Narrow runs stay in a small window so the walk is short and values repeat.
  function automatic int unsigned queue_random_run(int unsigned gap, int unsigned forced_len);
    int unsigned len;
    int unsigned window;
    logic [VALUE_BITS-1:0] base;
    logic [VALUE_BITS-1:0] v;
    bit wide;
    if (forced_len != 0) len = forced_len;
    else if ($urandom_range(99) < 10) len = $urandom_range(70, 58);
    else len = $urandom_range(12, 1);
    wide = 1'($urandom_range(1));
    base = VALUE_BITS'($urandom);
    window = $urandom_range(15);
    v = base;
    for (int unsigned k = 0; k < len; k++) begin
      if (k == 0 || $urandom_range(3) != 0)
        v = wide ? VALUE_BITS'($urandom) : base + VALUE_BITS'($urandom_range(window));
      queue_item(v, k == len - 1, gap, 1'b0);
    end
    return len;
  endfunction

  // Driver: the current transaction completes when start is high and busy low.
  always @(posedge clk) begin
    bit free;
    if (rst) begin
      start <= 1'b0;
    end else begin
      free = !start;
      if (start && !busy) begin
        sort_item(item);
        free = 1'b1;
      end
      if (free) begin
        if (item_backlog.size() != 0 &&
            (!item_backlog[0].drain_first || pending_sorted.size() == 0) &&
            $urandom_range(99) >= item_backlog[0].gap_pct) begin
          item <= item_backlog[0].payload;
          start <= 1'b1;
          void'(item_backlog.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is matched against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && strobe) begin
      if (pending_sorted.size() == 0) begin
        $error("unexpected result: sorted_value %0d end_of_run %0b overflow %0b",
               result.sorted_value, result.end_of_run, result.overflow);
        failures++;
      end else begin
        want = pending_sorted.pop_front();
        results_checked++;
        if (result.sorted_value !== want.sorted_value) begin
          $error("sorted_value: expected %0d, got %0d", want.sorted_value,
                 result.sorted_value);
          failures++;
        end
        if (result.end_of_run !== want.end_of_run) begin
          $error("end_of_run: expected %0b, got %0b", want.end_of_run, result.end_of_run);
          failures++;
        end
        if (result.overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, result.overflow);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > cycle_limit) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
               pending_sorted.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned gap_by_phase[3];
    int unsigned phase_items;
    gap_by_phase[0] = 30;
    gap_by_phase[1] = 70;
    gap_by_phase[2] = 0;
    clear_histogram();
    cycle_budget = 0;

    // Single-element runs at both extremes and at zero; the sender waits for
    // the previous list to drain before the second and third.
    queue_item(VALUE_BITS'(-512), 1'b1, 30, 1'b0);
    queue_item(VALUE_BITS'(511), 1'b1, 30, 1'b1);
    queue_item(VALUE_BITS'(0), 1'b1, 30, 1'b1);
    // Full span with duplicates, ending on a repeated minimum.
    queue_item(VALUE_BITS'(511), 1'b0, 0, 1'b0);
    queue_item(VALUE_BITS'(-512), 1'b0, 0, 1'b0);
    queue_item(VALUE_BITS'(0), 1'b0, 0, 1'b0);
    queue_item(VALUE_BITS'(-1), 1'b0, 0, 1'b0);
    queue_item(VALUE_BITS'(1), 1'b0, 0, 1'b0);
    queue_item(VALUE_BITS'(0), 1'b0, 0, 1'b0);
    queue_item(VALUE_BITS'(0), 1'b0, 0, 1'b0);
    queue_item(VALUE_BITS'(-512), 1'b1, 0, 1'b0);
    // Back-to-back identical values exercise the read-modify-write bypass.
    queue_item(VALUE_BITS'(5), 1'b0, 0, 1'b1);
    queue_item(VALUE_BITS'(5), 1'b0, 0, 1'b0);
    queue_item(VALUE_BITS'(5), 1'b0, 0, 1'b0);
    queue_item(VALUE_BITS'(5), 1'b1, 0, 1'b0);
    // Neighbors across the sign boundary.
    queue_item(VALUE_BITS'(-1), 1'b0, 30, 1'b0);
    queue_item(VALUE_BITS'(0), 1'b1, 30, 1'b0);

    for (int p = 0; p < 3; p++) begin
      phase_items = 0;
      if (p == 0) begin
        // Exactly full, then one over so the last-marked item is dropped.
        phase_items += queue_random_run(gap_by_phase[p], CAPACITY);
        phase_items += queue_random_run(gap_by_phase[p], CAPACITY + 1);
      end
      while (phase_items < PHASE_ITEMS)
        phase_items += queue_random_run(gap_by_phase[p], 0);
    end
    cycle_limit = 4 * cycle_budget + 4 * DEPTH + 1000;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (item_backlog.size() != 0 || start || pending_sorted.size() != 0)
      @(posedge clk);
    repeat (32) @(posedge clk);

    $display("Sorted %0d runs from %0d items, %0d of them with dropped elements.",
             runs_done, items_taken, overflow_runs);
    $display("Checked %0d results, %0d mismatches.", results_checked, failures);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
